// ===== hw/rtl/uer_pkg.sv =====
package uer_pkg;

  // Width of the free-running tick timer.
  localparam int unsigned TIMER_WIDTH = 16;

  // Field widths.
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned PULSE_W  = 16;
  localparam int unsigned DIST_W   = 11;
  localparam int unsigned GUARD_W  = 8;
  localparam int unsigned TRIG_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Centimeters per tick of echo: distance = pulse / 58. The divide is done as
  // a multiply by ceil(2^21 / 58) and a shift by 21.
  // This is exact for every 16-bit pulse value.
  localparam int unsigned CM_DIVISOR   = 58;
  localparam int unsigned RECIP_SHIFT  = 21;
  localparam int unsigned RECIP_MUL    = ((1 << RECIP_SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR;
  localparam int unsigned PROD_W       = PULSE_W + 16;

  // Largest pulse width that can be reported.
  localparam logic [31:0] PULSE_MAX = 32'h0000_FFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GUARD_LOW    = 2'd0,
    REG_TRIGGER_HIGH = 2'd1,
    REG_CLEAR_WAIT   = 2'd2,
    REG_ECHO_TIMEOUT = 2'd3
  } uer_reg_e;

  // Reset values of the configuration registers.
  localparam logic [GUARD_W-1:0] GUARD_LOW_RST    = 8'd2;
  localparam logic [TRIG_W-1:0]  TRIGGER_HIGH_RST = 8'd10;
  localparam logic [COUNT_W-1:0] CLEAR_WAIT_RST   = 16'd1000;
  localparam logic [COUNT_W-1:0] ECHO_TIMEOUT_RST = 16'd60000;

  // Measurement sequencer phases, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_CLEAR = 6'b000010,
    PH_GUARD = 6'b000100,
    PH_TRIG  = 6'b001000,
    PH_RISE  = 6'b010000,
    PH_FALL  = 6'b100000
  } uer_phase_e;

  // One input tick.
  typedef struct packed {
    logic start_req;
    logic echo;
  } uer_in_t;

  // One result.
  typedef struct packed {
    logic               trigger;
    logic               busy_res;
    logic               done_res;
    logic               valid_res;
    logic [PULSE_W-1:0] pulse_ticks;
    logic [DIST_W-1:0]  distance_cm;
  } uer_out_t;

  // A result before the distance has been worked out.
  typedef struct packed {
    logic               trigger;
    logic               busy_res;
    logic               done_res;
    logic               valid_res;
    logic [PULSE_W-1:0] pulse_ticks;
  } uer_tick_t;

endpackage

// ===== hw/rtl/uer_intf.sv =====
// Channel carrying one input tick.
interface uer_item_if;
  logic            valid;
  logic            ready;
  uer_pkg::uer_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Channel carrying one result.
interface uer_result_if;
  logic             valid;
  logic             ready;
  uer_pkg::uer_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface uer_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [uer_pkg::CFG_IDX_W-1:0]    index;
  logic [uer_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ultrasonic_echo_ranger_top.sv =====
// Ultrasonic echo ranger. Each input transfer is one 1 us tick carrying a start
// request and the sampled echo pin; each tick gives exactly one result with the
// trigger pin level, busy, done and valid flags, the latest echo width in ticks
// and that width divided by 58 as centimeters. One tick is taken every clock
// cycle while the result side keeps up. The first stage runs the measurement
// sequencer and the timer, the second does the divide by 58 as a single 16x16
// multiply. When the result side stalls, both stages hold and input ready drops
// in the same cycle. The configuration port is always ready and should be
// written only while no measurement is running.
module ultrasonic_echo_ranger_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  uer_item_if.sink            item_i,
  uer_result_if.source        result_o,
  uer_cfg_if.sink             cfg_i
);

  // Configuration registers.
  logic [uer_pkg::GUARD_W-1:0] guard_low_q;
  logic [uer_pkg::TRIG_W-1:0]  trigger_high_q;
  logic [uer_pkg::COUNT_W-1:0] clear_wait_q;
  logic [uer_pkg::COUNT_W-1:0] echo_timeout_q;

  // Sequencer state.
  uer_pkg::uer_phase_e             phase_q, phase_d;
  logic [uer_pkg::COUNT_W-1:0]     count_q, count_d;
  logic [uer_pkg::TIMER_WIDTH-1:0] free_timer_q;
  logic [uer_pkg::TIMER_WIDTH-1:0] rise_time_q, rise_time_d;
  logic                            echo_last_q;
  logic [uer_pkg::PULSE_W-1:0]     last_pulse_q, last_pulse_d;

  // Pipeline stages.
  logic                  stage_valid_q;
  uer_pkg::uer_tick_t    stage_q, stage_d;
  logic                  out_valid_q;
  uer_pkg::uer_out_t     out_q;

  logic advance;
  logic accept;

  // Sequencer helpers.
  logic                            rising;
  logic                            falling;
  logic                            done;
  logic [uer_pkg::COUNT_W-1:0]     count_inc;
  logic [uer_pkg::TIMER_WIDTH-1:0] diff;
  logic [31:0]                     diff_wide;
  logic [uer_pkg::PROD_W-1:0]      product;

  // The whole pipeline moves whenever the output register is free or drained.
  assign advance      = !out_valid_q || result_o.ready;
  assign item_i.ready = advance;
  assign accept       = item_i.valid && advance;
  assign cfg_i.ready  = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_low_q    <= uer_pkg::GUARD_LOW_RST;
      trigger_high_q <= uer_pkg::TRIGGER_HIGH_RST;
      clear_wait_q   <= uer_pkg::CLEAR_WAIT_RST;
      echo_timeout_q <= uer_pkg::ECHO_TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        uer_pkg::REG_GUARD_LOW:    guard_low_q    <= cfg_i.data[uer_pkg::GUARD_W-1:0];
        uer_pkg::REG_TRIGGER_HIGH: trigger_high_q <= cfg_i.data[uer_pkg::TRIG_W-1:0];
        uer_pkg::REG_CLEAR_WAIT:   clear_wait_q   <= cfg_i.data;
        uer_pkg::REG_ECHO_TIMEOUT: echo_timeout_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Measurement sequencer: next state and the result of this tick.
  always_comb begin
    phase_d      = phase_q;
    count_d      = count_q;
    rise_time_d  = rise_time_q;
    last_pulse_d = last_pulse_q;
    done         = 1'b0;
    stage_d      = '0;
    count_inc    = count_q + uer_pkg::COUNT_W'(1);
    rising       = item_i.data.echo && !echo_last_q;
    falling      = !item_i.data.echo && echo_last_q;
    diff         = free_timer_q - rise_time_q;
    diff_wide    = 32'(diff);

    case (phase_q)
      uer_pkg::PH_IDLE: begin
        if (item_i.data.start_req) begin
          phase_d = uer_pkg::PH_CLEAR;
          count_d = '0;
        end
      end
      uer_pkg::PH_CLEAR: begin
        // Wait for a stale echo to end, but not past the limit.
        if (!item_i.data.echo || count_q >= clear_wait_q) begin
          count_d = '0;
          phase_d = (guard_low_q == '0) ? uer_pkg::PH_TRIG : uer_pkg::PH_GUARD;
        end else begin
          count_d = count_inc;
        end
      end
      uer_pkg::PH_GUARD: begin
        count_d = count_inc;
        if (count_inc >= uer_pkg::COUNT_W'(guard_low_q)) begin
          phase_d = uer_pkg::PH_TRIG;
          count_d = '0;
        end
      end
      uer_pkg::PH_TRIG: begin
        stage_d.trigger = 1'b1;
        count_d = count_inc;
        if (count_inc >= uer_pkg::COUNT_W'(trigger_high_q)) begin
          phase_d = uer_pkg::PH_RISE;
          count_d = '0;
        end
      end
      uer_pkg::PH_RISE, uer_pkg::PH_FALL: begin
        // Capture the timer at the rising edge, measure at the falling edge.
        if (phase_q == uer_pkg::PH_RISE) begin
          if (rising) begin
            rise_time_d = free_timer_q;
            phase_d     = uer_pkg::PH_FALL;
          end
        end else if (falling) begin
          last_pulse_d = (diff_wide > uer_pkg::PULSE_MAX) ?
                         uer_pkg::PULSE_MAX[uer_pkg::PULSE_W-1:0] :
                         diff_wide[uer_pkg::PULSE_W-1:0];
          done              = 1'b1;
          stage_d.valid_res = 1'b1;
          phase_d           = uer_pkg::PH_IDLE;
          count_d           = '0;
        end
        // Timeout covers both edges together.
        if (!done) begin
          count_d = count_inc;
          if (count_inc >= echo_timeout_q) begin
            last_pulse_d      = '0;
            done              = 1'b1;
            stage_d.valid_res = 1'b0;
            phase_d           = uer_pkg::PH_IDLE;
            count_d           = '0;
          end
        end
      end
      default: begin
        phase_d = uer_pkg::PH_IDLE;
        count_d = '0;
      end
    endcase

    stage_d.busy_res    = (phase_q != uer_pkg::PH_IDLE);
    stage_d.done_res    = done;
    stage_d.pulse_ticks = last_pulse_d;
  end

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= uer_pkg::PH_IDLE;
      count_q      <= '0;
      free_timer_q <= '0;
      rise_time_q  <= '0;
      echo_last_q  <= 1'b0;
      last_pulse_q <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      count_q      <= count_d;
      free_timer_q <= free_timer_q + uer_pkg::TIMER_WIDTH'(1);
      rise_time_q  <= rise_time_d;
      echo_last_q  <= item_i.data.echo;
      last_pulse_q <= last_pulse_d;
    end
  end

  // First stage: sequencer result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (advance) begin
      stage_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
  end

  // Second stage: distance by reciprocal multiply.
  assign product = uer_pkg::PROD_W'(stage_q.pulse_ticks) *
                   uer_pkg::PROD_W'(uer_pkg::RECIP_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= stage_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && stage_valid_q) begin
      out_q.trigger     <= stage_q.trigger;
      out_q.busy_res    <= stage_q.busy_res;
      out_q.done_res    <= stage_q.done_res;
      out_q.valid_res   <= stage_q.valid_res;
      out_q.pulse_ticks <= stage_q.pulse_ticks;
      out_q.distance_cm <= product[uer_pkg::RECIP_SHIFT +: uer_pkg::DIST_W];
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

`ifndef SYNTHESIS
  // A start request in idle always opens the stale echo wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == uer_pkg::PH_IDLE && item_i.data.start_req
    |=> phase_q == uer_pkg::PH_CLEAR)
    else $error("start in idle did not enter the clear phase");

  // A finished measurement returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && done |=> phase_q == uer_pkg::PH_IDLE)
    else $error("sequencer not idle after a finished measurement");

  // The timer moves by exactly one per accepted tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> free_timer_q == $past(free_timer_q) + uer_pkg::TIMER_WIDTH'(1))
    else $error("free timer did not step by one");

  // The distance is the floor of the pulse width divided by 58.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      (32'(out_q.distance_cm) * uer_pkg::CM_DIVISOR <= 32'(out_q.pulse_ticks)) &&
      (32'(out_q.pulse_ticks) < (32'(out_q.distance_cm) + 32'd1) * uer_pkg::CM_DIVISOR))
    else $error("distance does not match pulse width");
`endif

endmodule

// ===== sim/ultrasonic_echo_ranger_top_tb.sv =====
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_top_tb;
  import uer_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 4;
  // Extra clocks to wait once every outstanding reading has come back.
  localparam int PIPE_CYCLES  = 4;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_TICKS = 180;
  localparam int MAX_REPORTS  = 10;

  // One row of the directed sequence: a tick, or a register write.
  typedef struct {
    logic                  is_cfg;
    logic                  start;
    logic                  echo;
    uer_reg_e              sel;
    logic [CFG_DATA_W-1:0] value;
    logic                  typed;
    uer_out_t              want;
  } drill_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  uer_item_if   item_ch ();
  uer_result_if result_ch ();
  uer_cfg_if    cfg_ch ();

  ultrasonic_echo_ranger_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_ch),
    .result_o(result_ch),
    .cfg_i   (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Ranger registers as the predictor sees them.
  logic [GUARD_W-1:0]     cfg_guard;
  logic [TRIG_W-1:0]      cfg_trig;
  logic [COUNT_W-1:0]     cfg_clear;
  logic [COUNT_W-1:0]     cfg_timeout;

  // Ranger state as the predictor sees it.
  uer_phase_e             rng_phase;
  logic [COUNT_W-1:0]     rng_count;
  logic [TIMER_WIDTH-1:0] rng_timer;
  logic [TIMER_WIDTH-1:0] rng_rise;
  logic                   rng_echo_q;
  logic [PULSE_W-1:0]     rng_pulse;

  uer_out_t   pending_readings[$];
  drill_row_t drill_q[$];
  int         ticks_sent   = 0;
  int         bad_readings = 0;
  int         send_calm    = 0;
  int         recv_calm    = 0;
  bit         quiet        = 1'b0;
  int         stall_cycles = 0;

  // Wait before the next transfer; now and then a run with no waits at all.
  function automatic int draw_wait(inout int calm_left);
    if (quiet) return 0;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic uer_out_t outcome(input logic trig, input logic busy, input logic done,
                                       input logic valid, input logic [PULSE_W-1:0] pulse,
                                       input logic [DIST_W-1:0] range_cm);
    uer_out_t r;
    r.trigger     = trig;
    r.busy_res    = busy;
    r.done_res    = done;
    r.valid_res   = valid;
    r.pulse_ticks = pulse;
    r.distance_cm = range_cm;
    return r;
  endfunction

  function automatic drill_row_t tick_row(input logic start, input logic echo);
    drill_row_t r;
    r = '{is_cfg: 1'b0, start: start, echo: echo, sel: REG_GUARD_LOW, value: '0,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic drill_row_t known_row(input logic start, input logic echo,
                                           input uer_out_t want);
    drill_row_t r;
    r = tick_row(start, echo);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic drill_row_t cfg_row(input uer_reg_e sel, input logic [CFG_DATA_W-1:0] v);
    drill_row_t r;
    r = tick_row(1'b0, 1'b0);
    r.is_cfg = 1'b1;
    r.sel    = sel;
    r.value  = v;
    return r;
  endfunction

  // Advance the predicted ranger by one tick and return the reading it gives.
  function automatic uer_out_t advance_ranger(input logic start, input logic echo);
    logic [TIMER_WIDTH-1:0] now;
    logic [TIMER_WIDTH-1:0] span;
    logic                   rising;
    logic                   falling;
    uer_out_t               r;
    now     = rng_timer;
    rising  = echo && !rng_echo_q;
    falling = !echo && rng_echo_q;
    r = '0;
    r.busy_res = (rng_phase != PH_IDLE);
    case (rng_phase)
      PH_IDLE: begin
        if (start) begin
          rng_phase = PH_CLEAR;
          rng_count = '0;
        end
      end
      PH_CLEAR: begin
        // A stale echo holds the sequence here until it ends or the limit is hit.
        if (!echo || rng_count >= cfg_clear) begin
          rng_count = '0;
          rng_phase = (cfg_guard == '0) ? PH_TRIG : PH_GUARD;
        end else begin
          rng_count = rng_count + COUNT_W'(1);
        end
      end
      PH_GUARD: begin
        rng_count = rng_count + COUNT_W'(1);
        if (rng_count >= COUNT_W'(cfg_guard)) begin
          rng_phase = PH_TRIG;
          rng_count = '0;
        end
      end
      PH_TRIG: begin
        r.trigger = 1'b1;
        rng_count = rng_count + COUNT_W'(1);
        if (rng_count >= COUNT_W'(cfg_trig)) begin
          rng_phase = PH_RISE;
          rng_count = '0;
        end
      end
      PH_RISE, PH_FALL: begin
        if (rng_phase == PH_RISE) begin
          if (rising) begin
            rng_rise  = now;
            rng_phase = PH_FALL;
          end
        end else if (falling) begin
          span        = now - rng_rise;
          rng_pulse   = (32'(span) > PULSE_MAX) ? PULSE_W'(PULSE_MAX) : PULSE_W'(span);
          r.done_res  = 1'b1;
          r.valid_res = 1'b1;
          rng_phase   = PH_IDLE;
          rng_count   = '0;
        end
        // The timeout covers the wait for both edges together.
        if (!r.done_res) begin
          rng_count = rng_count + COUNT_W'(1);
          if (rng_count >= cfg_timeout) begin
            rng_pulse  = '0;
            r.done_res = 1'b1;
            rng_phase  = PH_IDLE;
            rng_count  = '0;
          end
        end
      end
      default: begin
        rng_phase = PH_IDLE;
        rng_count = '0;
      end
    endcase
    r.pulse_ticks = rng_pulse;
    r.distance_cm = DIST_W'(rng_pulse / CM_DIVISOR);
    rng_echo_q = echo;
    rng_timer  = now + TIMER_WIDTH'(1);
    return r;
  endfunction

  // Present one tick, wait for its transfer and record the reading it should give.
  task automatic send_tick(input logic start, input logic echo, input logic typed,
                           input uer_out_t want);
    int       gap;
    uer_out_t predicted;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= '{start_req: start, echo: echo};
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    predicted = advance_ranger(start, echo);
    pending_readings.push_back(typed ? want : predicted);
    ticks_sent++;
  endtask

  // Stop sending and let every outstanding reading come back.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input uer_reg_e sel, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data  <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (sel)
      REG_GUARD_LOW:    cfg_guard   = value[GUARD_W-1:0];
      REG_TRIGGER_HIGH: cfg_trig    = value[TRIG_W-1:0];
      REG_CLEAR_WAIT:   cfg_clear   = value;
      REG_ECHO_TIMEOUT: cfg_timeout = value;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Rewrite all four registers once the ranger has gone quiet.
  task automatic program_ranger(input logic [GUARD_W-1:0] guard, input logic [TRIG_W-1:0] trig,
                                input logic [COUNT_W-1:0] clear,
                                input logic [COUNT_W-1:0] timeout);
    logic [7:0] junk;
    drain_results();
    // The upper byte of an 8-bit register write is dropped by the block.
    junk = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
    write_reg(REG_GUARD_LOW, {junk, guard});
    junk = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
    write_reg(REG_TRIGGER_HIGH, {junk, trig});
    write_reg(REG_CLEAR_WAIT, clear);
    write_reg(REG_ECHO_TIMEOUT, timeout);
  endtask

  task automatic idle_noise(input int count);
    repeat (count) send_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  // One measurement: a stale echo, a delay after the trigger, then an echo pulse.
  task automatic run_ping(input int stale, input int delay, input int width, input bit noisy);
    int   stale_left;
    int   delay_left;
    int   high_left;
    logic echo;
    stale_left = stale;
    delay_left = delay;
    high_left  = width;
    send_tick(1'b1, stale_left > 0, 1'b0, '0);
    while (rng_phase != PH_IDLE) begin
      if (rng_phase != PH_RISE && rng_phase != PH_FALL) begin
        if (stale_left > 0) begin
          echo = 1'b1;
          stale_left--;
        end else begin
          echo = noisy ? 1'($urandom_range(0, 1)) : 1'b0;
        end
      end else if (delay_left > 0) begin
        echo = noisy ? 1'($urandom_range(0, 1)) : 1'b0;
        delay_left--;
      end else if (high_left > 0) begin
        echo = 1'b1;
        high_left--;
      end else begin
        echo = 1'b0;
      end
      // Start requests while busy must be ignored.
      send_tick($urandom_range(0, 3) == 0, echo, 1'b0, '0);
    end
  endtask

  // Reading side: stall at random, then check each transfer against the oldest reading.
  initial begin
    int       gap;
    uer_out_t want;
    uer_out_t got;
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_wait(recv_calm);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (result_ch.valid !== 1'b1) @(posedge clk_i);
      got = result_ch.data;
      if (pending_readings.size() == 0) begin
        bad_readings++;
        if (bad_readings <= MAX_REPORTS) begin
          $display("Unexpected reading: trig %b busy %b done %b valid %b pulse %0d dist %0d",
                   got.trigger, got.busy_res, got.done_res, got.valid_res,
                   got.pulse_ticks, got.distance_cm);
        end
      end else begin
        want = pending_readings.pop_front();
        if (got.trigger !== want.trigger || got.busy_res !== want.busy_res ||
            got.done_res !== want.done_res || got.valid_res !== want.valid_res ||
            got.pulse_ticks !== want.pulse_ticks || got.distance_cm !== want.distance_cm) begin
          bad_readings++;
          if (bad_readings <= MAX_REPORTS) begin
            $display("Reading mismatch at %0t: expected trig %b busy %b done %b valid %b %s",
                     $realtime, want.trigger, want.busy_res, want.done_res, want.valid_res,
                     $sformatf("pulse %0d dist %0d", want.pulse_ticks, want.distance_cm));
            $display("  got trig %b busy %b done %b valid %b pulse %0d dist %0d",
                     got.trigger, got.busy_res, got.done_res, got.valid_res,
                     got.pulse_ticks, got.distance_cm);
          end
        end
      end
    end
  end

  // Watchdog: give up when no transfer happens on any channel for too long.
  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus: directed sequence, random measurements, then the longest registers.
  initial begin
    drill_row_t row;
    int         phase_no;
    int         pings;
    int         kind;
    int         width;
    int         stop_at;
    rst_ni        = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;

    cfg_guard   = GUARD_LOW_RST;
    cfg_trig    = TRIGGER_HIGH_RST;
    cfg_clear   = CLEAR_WAIT_RST;
    cfg_timeout = ECHO_TIMEOUT_RST;
    rng_phase   = PH_IDLE;
    rng_count   = '0;
    rng_timer   = '0;
    rng_rise    = '0;
    rng_echo_q  = 1'b0;
    rng_pulse   = '0;

    // Reset values: a stale echo, a guard of two ticks, a ten-tick trigger pulse,
    // then a two-tick echo.
    drill_q.push_back(known_row(1'b0, 1'b0, outcome(1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 11'd0)));
    drill_q.push_back(known_row(1'b1, 1'b1, outcome(1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 11'd0)));
    drill_q.push_back(tick_row(1'b0, 1'b1));
    drill_q.push_back(tick_row(1'b1, 1'b0));
    drill_q.push_back(tick_row(1'b0, 1'b1));
    drill_q.push_back(tick_row(1'b0, 1'b1));
    for (int i = 0; i < TRIGGER_HIGH_RST; i++) drill_q.push_back(tick_row(1'b0, 1'b0));
    drill_q.push_back(tick_row(1'b0, 1'b1));
    drill_q.push_back(tick_row(1'b0, 1'b1));
    drill_q.push_back(known_row(1'b0, 1'b0, outcome(1'b0, 1'b1, 1'b1, 1'b1, 16'd2, 11'd0)));
    drill_q.push_back(known_row(1'b0, 1'b0, outcome(1'b0, 1'b0, 1'b0, 1'b0, 16'd2, 11'd0)));
    // No guard, and zero trigger and timeout widths acting as one tick.
    drill_q.push_back(cfg_row(REG_GUARD_LOW, 16'd0));
    drill_q.push_back(cfg_row(REG_TRIGGER_HIGH, 16'd0));
    drill_q.push_back(cfg_row(REG_ECHO_TIMEOUT, 16'd0));
    drill_q.push_back(tick_row(1'b1, 1'b0));
    drill_q.push_back(tick_row(1'b0, 1'b0));
    drill_q.push_back(tick_row(1'b0, 1'b0));
    drill_q.push_back(known_row(1'b0, 1'b0, outcome(1'b0, 1'b1, 1'b1, 1'b0, 16'd0, 11'd0)));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (drill_q[i]) begin
      row = drill_q[i];
      if (row.is_cfg) begin
        drain_results();
        write_reg(row.sel, row.value);
      end else begin
        send_tick(row.start, row.echo, row.typed, row.want);
      end
    end

    // Random measurements, a few register settings in turn.
    stop_at  = ticks_sent + RANDOM_TICKS;
    phase_no = 0;
    while (ticks_sent < stop_at) begin
      case (phase_no)
        0:       program_ranger(8'd0, 8'd1, 16'd0, 16'd1);
        1:       program_ranger(8'd1, 8'd1, 16'hFFFF, 16'hFFFF);
        2:       program_ranger(8'd0, 8'd0, 16'd3, 16'd0);
        default: program_ranger(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 12)),
                                ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 12)),
                                16'($urandom_range(0, 25)), 16'($urandom_range(8, 250)));
      endcase
      pings = $urandom_range(2, 5);
      repeat (pings) begin
        idle_noise($urandom_range(0, 6));
        kind  = $urandom_range(0, 9);
        width = $urandom_range(1, 180);
        // An echo that never comes is only tried where the timeout is short.
        if (kind == 6 && cfg_timeout <= 1000) width = 0;
        run_ping((kind == 9) ? $urandom_range(1, 30) : 0, $urandom_range(0, 15), width,
                 kind == 7 || kind == 8);
      end
      phase_no++;
    end

    // Longest guard and trigger registers with a short echo.
    program_ranger(8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
    quiet = 1'b1;
    run_ping(5, 0, 20, 1'b0);
    quiet = 1'b0;
    idle_noise(5);
    drain_results();

    if (bad_readings == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== ultrasonic_echo_ranger_top.f =====
hw/rtl/uer_pkg.sv
hw/rtl/uer_intf.sv
hw/rtl/ultrasonic_echo_ranger_top.sv
sim/ultrasonic_echo_ranger_top_tb.sv
